// File: design/ffba_pkg.sv
// Shared constants, types and helper functions of the block allocator.
`default_nettype none

package ffba_pkg;

    // Pool geometry.
    localparam int POOL_DEPTH = 1024;
    localparam int ADDR_W     = $clog2(POOL_DEPTH);
    localparam int SIZE_W     = $clog2(POOL_DEPTH + 1);

    // Fixed widths of the beat fields and the configuration register.
    localparam int OP_W     = 2;
    localparam int BLOCK_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int FAIL_W   = 32;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 11;

    localparam logic [CFG_W-1:0]  POOL_BLOCKS_RST = CFG_W'(1024);
    localparam logic [FAIL_W-1:0] FAIL_MAX        = '1;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
    localparam logic [OP_W-1:0] OP_REFILL = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_USED  = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE     = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic sweep;
        logic exec;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } dp_status_t;

    // A pool size of zero or anything above the depth means the whole depth.
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_W-1:0] pb);
        logic [SIZE_W-1:0] n;
        if (pb == '0 || 32'(pb) > POOL_DEPTH) begin
            n = SIZE_W'(POOL_DEPTH);
        end else begin
            n = SIZE_W'(pb);
        end
        return n;
    endfunction

    // Queue tail after a refill: just past the last free index.
    function automatic logic [ADDR_W-1:0] refill_tail(input logic [SIZE_W-1:0] n);
        logic [ADDR_W-1:0] t;
        if (32'(n) >= POOL_DEPTH) begin
            t = '0;
        end else begin
            t = ADDR_W'(n);
        end
        return t;
    endfunction

    function automatic logic [ADDR_W-1:0] wrap_next(input logic [ADDR_W-1:0] p);
        logic [ADDR_W-1:0] q;
        if (p == ADDR_W'(POOL_DEPTH - 1)) begin
            q = '0;
        end else begin
            q = p + ADDR_W'(1);
        end
        return q;
    endfunction

endpackage

`default_nettype wire

// File: design/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// File: design/ffba_ctrl.sv
// Controller state machine of the block allocator.
`default_nettype none

module ffba_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    input  wire logic [1:0]           s_operation,
    output logic                      s_ready,
    input  wire ffba_pkg::dp_status_t stat,
    output ffba_pkg::ctrl_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_EXEC
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT: begin
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_operation == ffba_pkg::OP_REFILL) ? ST_CLEAR : ST_EXEC;
                end
            end
            ST_CLEAR: begin
                if (stat.sweep_last) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready    = (state_reg == ST_IDLE);
    assign cmd.accept = (state_reg == ST_IDLE) && s_valid;
    assign cmd.sweep  = (state_reg == ST_INIT) || (state_reg == ST_CLEAR);
    assign cmd.exec   = (state_reg == ST_EXEC) && stat.out_free;

endmodule

`default_nettype wire

// File: design/ffba_datapath.sv
// Datapath of the block allocator: queue and mark memories, counters, output register.
`default_nettype none

module ffba_datapath (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire ffba_pkg::ctrl_cmd_t                    cmd,
    output ffba_pkg::dp_status_t                        stat,
    input  wire logic [ffba_pkg::OP_W-1:0]              s_operation,
    input  wire logic [ffba_pkg::BLOCK_W-1:0]           s_block_index,
    input  wire logic                                   cfg_we,
    input  wire logic [ffba_pkg::CFG_W-1:0]             cfg_wdata,
    input  wire logic                                   m_ready,
    output logic                                        m_valid,
    output logic      [ffba_pkg::STATUS_W-1:0]          m_status,
    output logic      [ffba_pkg::BLOCK_W-1:0]           m_granted_index,
    output logic      [ffba_pkg::COUNT_W-1:0]           m_used_count,
    output logic      [ffba_pkg::FAIL_W-1:0]            m_failure_count
);

    localparam int AW = ffba_pkg::ADDR_W;
    localparam int SW = ffba_pkg::SIZE_W;

    logic [ffba_pkg::CFG_W-1:0]    pool_blocks_reg;
    logic [SW-1:0]                 active_reg, active_next;
    logic [AW-1:0]                 head_reg, head_next;
    logic [AW-1:0]                 tail_reg, tail_next;
    logic [SW-1:0]                 free_cnt_reg, free_cnt_next;
    logic [SW-1:0]                 used_reg, used_next;
    logic [ffba_pkg::FAIL_W-1:0]   fail_reg, fail_next;
    logic [AW-1:0]                 sweep_reg, sweep_next;
    logic [ffba_pkg::OP_W-1:0]     op_reg;
    logic [ffba_pkg::BLOCK_W-1:0]  idx_reg;

    logic                          m_valid_reg;
    logic [ffba_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [ffba_pkg::BLOCK_W-1:0]  m_granted_reg, m_granted_next;
    logic [ffba_pkg::COUNT_W-1:0]  m_used_reg;
    logic [ffba_pkg::FAIL_W-1:0]   m_fail_reg;

    logic [AW-1:0] q_rdata;
    logic [0:0]    mk_rdata;
    logic          q_we, mk_we;
    logic [AW-1:0] q_waddr, q_wdata, mk_waddr;
    logic [0:0]    mk_wdata;

    logic [AW-1:0] idx_a;
    logic          in_range, alloc_ok, free_ok;

    assign idx_a    = AW'(idx_reg);
    assign in_range = 32'(idx_reg) < 32'(active_reg);
    assign alloc_ok = (op_reg == ffba_pkg::OP_ALLOC) && (free_cnt_reg != '0);
    assign free_ok  = (op_reg == ffba_pkg::OP_FREE) && in_range && mk_rdata[0];

    assign stat.sweep_last = (sweep_reg == AW'(ffba_pkg::POOL_DEPTH - 1));
    assign stat.out_free   = !m_valid_reg || m_ready;

    // Memory write ports: the sweep owns them while it runs.
    always_comb begin
        q_we     = cmd.sweep || (cmd.exec && free_ok);
        q_waddr  = cmd.sweep ? sweep_reg : tail_reg;
        q_wdata  = cmd.sweep ? sweep_reg : idx_a;
        mk_we    = cmd.sweep || (cmd.exec && (alloc_ok || free_ok));
        mk_waddr = cmd.sweep ? sweep_reg : (alloc_ok ? q_rdata : idx_a);
        mk_wdata = 1'((!cmd.sweep) && alloc_ok);
    end

    ffba_ram #(
        .WIDTH (AW),
        .DEPTH (ffba_pkg::POOL_DEPTH)
    ) u_queue (
        .aclk  (aclk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .re    (cmd.accept),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    ffba_ram #(
        .WIDTH (1),
        .DEPTH (ffba_pkg::POOL_DEPTH)
    ) u_marks (
        .aclk  (aclk),
        .we    (mk_we),
        .waddr (mk_waddr),
        .wdata (mk_wdata),
        .re    (cmd.accept),
        .raddr (AW'(s_block_index)),
        .rdata (mk_rdata)
    );

    always_comb begin
        active_next    = active_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        free_cnt_next  = free_cnt_reg;
        used_next      = used_reg;
        fail_next      = fail_reg;
        sweep_next     = sweep_reg;
        m_status_next  = ffba_pkg::STAT_OK;
        m_granted_next = '0;

        if (cmd.sweep) begin
            sweep_next = stat.sweep_last ? '0 : sweep_reg + AW'(1);
        end

        if (cmd.accept && s_operation == ffba_pkg::OP_REFILL) begin
            active_next   = ffba_pkg::clamp_size(pool_blocks_reg);
            head_next     = '0;
            tail_next     = ffba_pkg::refill_tail(active_next);
            free_cnt_next = active_next;
            used_next     = '0;
        end

        if (cmd.exec) begin
            unique case (op_reg)
                ffba_pkg::OP_ALLOC: begin
                    if (alloc_ok) begin
                        head_next      = ffba_pkg::wrap_next(head_reg);
                        free_cnt_next  = free_cnt_reg - SW'(1);
                        used_next      = used_reg + SW'(1);
                        m_granted_next = ffba_pkg::BLOCK_W'(q_rdata);
                    end else begin
                        m_status_next = ffba_pkg::STAT_EXHAUSTED;
                        if (fail_reg != ffba_pkg::FAIL_MAX) begin
                            fail_next = fail_reg + ffba_pkg::FAIL_W'(1);
                        end
                    end
                end
                ffba_pkg::OP_FREE: begin
                    if (!in_range) begin
                        m_status_next = ffba_pkg::STAT_RANGE;
                    end else if (!mk_rdata[0]) begin
                        m_status_next = ffba_pkg::STAT_NOT_USED;
                    end else begin
                        tail_next     = ffba_pkg::wrap_next(tail_reg);
                        free_cnt_next = free_cnt_reg + SW'(1);
                        if (used_reg != '0) begin
                            used_next = used_reg - SW'(1);
                        end
                    end
                end
                default: m_status_next = ffba_pkg::STAT_OK;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pool_blocks_reg <= ffba_pkg::POOL_BLOCKS_RST;
            active_reg      <= ffba_pkg::clamp_size(ffba_pkg::POOL_BLOCKS_RST);
            head_reg        <= '0;
            tail_reg        <= ffba_pkg::refill_tail(
                                   ffba_pkg::clamp_size(ffba_pkg::POOL_BLOCKS_RST));
            free_cnt_reg    <= ffba_pkg::clamp_size(ffba_pkg::POOL_BLOCKS_RST);
            used_reg        <= '0;
            fail_reg        <= '0;
            sweep_reg       <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (cfg_we) begin
                pool_blocks_reg <= cfg_wdata;
            end
            active_reg   <= active_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            free_cnt_reg <= free_cnt_next;
            used_reg     <= used_next;
            fail_reg     <= fail_next;
            sweep_reg    <= sweep_next;
            if (cmd.exec) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= s_operation;
            idx_reg <= s_block_index;
        end
        if (cmd.exec) begin
            m_status_reg  <= m_status_next;
            m_granted_reg <= m_granted_next;
            m_used_reg    <= ffba_pkg::COUNT_W'(used_next);
            m_fail_reg    <= fail_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_granted_reg;
    assign m_used_count    = m_used_reg;
    assign m_failure_count = m_fail_reg;

endmodule

`default_nettype wire

// File: design/fifo_free_list_block_allocator_core.sv
// Allocate, free and no-op are accepted in ST_IDLE with the registered read of the queue
// and mark memories; ST_EXEC then commits the update and shows the result beat, waiting
// while the output register holds an untaken result. A new request is taken only after
// that commit. A pool reset operation walks all POOL_DEPTH entries of both memories, one
// per cycle, in ST_CLEAR before its ST_EXEC step. After aresetn the same pass runs in
// ST_INIT with s_ready low; configuration writes are taken at any time.
`default_nettype none

module fifo_free_list_block_allocator_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Configuration: pool size, applied at the next pool reset.
    input  wire logic                                cfg_we,
    input  wire logic [ffba_pkg::CFG_W-1:0]          cfg_wdata,
    // Request channel.
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ffba_pkg::OP_W-1:0]           s_operation,
    input  wire logic [ffba_pkg::BLOCK_W-1:0]        s_block_index,
    // Result channel.
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic      [ffba_pkg::STATUS_W-1:0]       m_status,
    output logic      [ffba_pkg::BLOCK_W-1:0]        m_granted_index,
    output logic      [ffba_pkg::COUNT_W-1:0]        m_used_count,
    output logic      [ffba_pkg::FAIL_W-1:0]         m_failure_count
);

    // The controller sequences each request beat: it accepts the beat, lets the
    // memories return the queue head and the mark of the addressed block, and then
    // commits the update together with loading the output register. The update only
    // fires when the output register is empty or being drained, so a result never
    // overwrites an untaken one, while the next request beat may already be accepted.
    ffba_pkg::ctrl_cmd_t  cmd;
    ffba_pkg::dp_status_t stat;

    ffba_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_operation (s_operation),
        .s_ready     (s_ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    // The datapath keeps the circular free queue and the used marks in two RAMs.
    // Both are rewritten by a sweep after reset and on a pool reset operation: the
    // queue gets every index in order and every mark is cleared. The counters that
    // describe the queue are loaded when that sweep starts.
    ffba_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .stat            (stat),
        .s_operation     (s_operation),
        .s_block_index   (s_block_index),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .m_ready         (m_ready),
        .m_valid         (m_valid),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_used_count    (m_used_count),
        .m_failure_count (m_failure_count)
    );

endmodule

`default_nettype wire

// File: tb/fifo_free_list_block_allocator_core_tb.sv
// Self-checking testbench for the fifo free-list block allocator core.
`timescale 1ns / 100ps

module fifo_free_list_block_allocator_core_tb;
    import ffba_pkg::*;

    // The clock runs at 20 ns. The cycle limit is far above the slowest legal run:
    // about 1700 beats, stretched by sender gaps and receiver stalls, plus the
    // clearing pass after reset and about a dozen pool reset walks over all
    // POOL_DEPTH entries each.
    localparam int HALF_PERIOD  = 10;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 16;

    // One result beat, field by field.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BLOCK_W-1:0]  granted;
        logic [COUNT_W-1:0]  used;
        logic [FAIL_W-1:0]   failures;
    } alloc_result_t;

    // One row of the directed table: either a pool size write or a request beat.
    // A request row with a typed result is checked against that result; any
    // other request row is checked against the allocator model below.
    typedef struct packed {
        bit                 is_cfg;
        logic [CFG_W-1:0]   cfg_value;
        logic [OP_W-1:0]    op;
        logic [BLOCK_W-1:0] idx;
        bit                 typed;
        alloc_result_t      result;
    } test_row_t;

    typedef enum int {READY_ALWAYS, READY_HALF, READY_SPARSE} ready_mode_t;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_we;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                s_valid;
    logic                s_ready;
    logic [OP_W-1:0]     s_operation;
    logic [BLOCK_W-1:0]  s_block_index;
    logic                m_valid;
    logic                m_ready;
    logic [STATUS_W-1:0] m_status;
    logic [BLOCK_W-1:0]  m_granted_index;
    logic [COUNT_W-1:0]  m_used_count;
    logic [FAIL_W-1:0]   m_failure_count;

    fifo_free_list_block_allocator_core DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_block_index   (s_block_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_index (m_granted_index),
        .m_used_count    (m_used_count),
        .m_failure_count (m_failure_count)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    // Allocator model state. The free ring is a circular queue over the full
    // depth, independent of the active pool size, exactly as the block keeps it.
    logic [ADDR_W-1:0]  free_ring [POOL_DEPTH];
    bit                 block_held [POOL_DEPTH];
    logic [ADDR_W-1:0]  ring_head;
    logic [ADDR_W-1:0]  ring_tail;
    logic [SIZE_W-1:0]  ring_free;
    logic [SIZE_W-1:0]  pool_size;
    logic [COUNT_W-1:0] held_total;
    logic [FAIL_W-1:0]  failed_total;
    logic [CFG_W-1:0]   pool_cfg;

    // Blocks currently handed out, kept so that the stimulus can free live blocks.
    int                 held_blocks [$];

    // Results still owed by the block, oldest first.
    alloc_result_t      pending_results [$];

    // Directed table, walked in order after reset.
    test_row_t          directed_rows [$];

    int                 error_count = 0;
    int                 cycle_count = 0;
    int                 burst_left;
    bit                 hold_request;
    bit                 hold_done = 1'b0;

    function automatic logic [ADDR_W-1:0] ring_advance(input logic [ADDR_W-1:0] p);
        return (p == ADDR_W'(POOL_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic void add_row(input test_row_t t);
        directed_rows.insert(directed_rows.size(), t);
    endfunction

    // Latch the pool size and put every block back on the ring in index order.
    // A size of zero, or anything past the depth, means the whole depth.
    task automatic refill_pool_model();
        logic [SIZE_W-1:0] n;
        n = SIZE_W'(pool_cfg);
        if (n == '0 || int'(n) > POOL_DEPTH) begin
            n = SIZE_W'(POOL_DEPTH);
        end
        pool_size = n;
        for (int i = 0; i < POOL_DEPTH; i++) begin
            free_ring[i]  = ADDR_W'(i);
            block_held[i] = 1'b0;
        end
        ring_head  = '0;
        ring_tail  = (int'(n) >= POOL_DEPTH) ? '0 : ADDR_W'(n);
        ring_free  = n;
        held_total = '0;
        held_blocks.delete();
    endtask

    // Apply one request to the model and return the result beat it must produce.
    task automatic allocator_step(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] idx,
                                  output alloc_result_t r);
        logic [ADDR_W-1:0] blk;
        r = '0;
        case (op)
            OP_ALLOC: begin
                if (ring_free == '0) begin
                    r.status = STAT_EXHAUSTED;
                    if (failed_total != FAIL_MAX) begin
                        failed_total = failed_total + 1'b1;
                    end
                end else begin
                    blk             = free_ring[ring_head];
                    ring_head       = ring_advance(ring_head);
                    ring_free       = ring_free - 1'b1;
                    block_held[blk] = 1'b1;
                    held_total      = held_total + 1'b1;
                    r.granted       = BLOCK_W'(blk);
                    held_blocks.insert(held_blocks.size(), int'(blk));
                end
            end
            OP_FREE: begin
                if (SIZE_W'(idx) >= pool_size) begin
                    r.status = STAT_RANGE;
                end else if (!block_held[idx]) begin
                    r.status = STAT_NOT_USED;
                end else begin
                    block_held[idx]      = 1'b0;
                    free_ring[ring_tail] = ADDR_W'(idx);
                    ring_tail            = ring_advance(ring_tail);
                    ring_free            = ring_free + 1'b1;
                    if (held_total != '0) begin
                        held_total = held_total - 1'b1;
                    end
                    for (int k = 0; k < held_blocks.size(); k++) begin
                        if (held_blocks[k] == int'(idx)) begin
                            held_blocks.delete(k);
                            break;
                        end
                    end
                end
            end
            OP_REFILL: begin
                refill_pool_model();
            end
            default: begin
                // The unused code leaves everything as it is.
            end
        endcase
        r.used     = held_total;
        r.failures = failed_total;
    endtask

    function automatic test_row_t row_config(input logic [CFG_W-1:0] v);
        test_row_t t;
        t = '0;
        t.is_cfg    = 1'b1;
        t.cfg_value = v;
        return t;
    endfunction

    function automatic test_row_t row_item(input logic [OP_W-1:0] op,
                                           input logic [BLOCK_W-1:0] idx);
        test_row_t t;
        t = '0;
        t.op  = op;
        t.idx = idx;
        return t;
    endfunction

    function automatic test_row_t row_checked(input logic [OP_W-1:0] op,
                                              input logic [BLOCK_W-1:0] idx,
                                              input logic [STATUS_W-1:0] st,
                                              input logic [BLOCK_W-1:0] granted,
                                              input logic [COUNT_W-1:0] used,
                                              input logic [FAIL_W-1:0] failures);
        test_row_t t;
        t        = row_item(op, idx);
        t.typed  = 1'b1;
        t.result = '{st, granted, used, failures};
        return t;
    endfunction

    // Offer one request beat. The sender works in bursts: when a burst runs out,
    // valid drops for a random gap before the next burst begins. Inside a burst,
    // valid stays high from beat to beat. Every call starts and ends at a falling edge.
    task automatic send_request(input logic [OP_W-1:0] op, input logic [BLOCK_W-1:0] idx,
                                input bit typed, input alloc_result_t typed_result);
        alloc_result_t predicted;
        int gap;
        if (burst_left == 0) begin
            s_valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_valid       = 1'b1;
        s_operation   = op;
        s_block_index = idx;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        allocator_step(op, idx, predicted);
        pending_results.insert(pending_results.size(), typed ? typed_result : predicted);
        @(negedge aclk);
    endtask

    // Stop offering beats and wait until every owed result has come back.
    task automatic drain_results();
        s_valid = 1'b0;
        while (pending_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Pool size write, only with the block idle. It takes effect at the next pool reset.
    task automatic write_pool_blocks(input logic [CFG_W-1:0] v);
        drain_results();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(posedge aclk);
        pool_cfg = v;
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    // One random phase. In fill mode almost every beat allocates, with a few frees
    // of live blocks, so the ring read pointer wraps past the end of the depth and
    // the pool runs dry. Otherwise the mix churns allocates and frees of live
    // blocks, with a share of noise: the unused code, pool resets now and then,
    // and frees of random or boundary indices that hit the error paths.
    task automatic run_phase(input logic [CFG_W-1:0] cfg_value, input bit with_refill,
                             input bit with_hold, input int count, input bit fill);
        int                 pick;
        logic [OP_W-1:0]    op;
        logic [BLOCK_W-1:0] idx;
        write_pool_blocks(cfg_value);
        if (with_refill) begin
            send_request(OP_REFILL, BLOCK_W'($urandom), 1'b0, '0);
        end
        if (with_hold) begin
            // Let the pool reset walk finish, then starve the result side while
            // the sender keeps pushing, so the block backs up onto its input.
            drain_results();
            hold_request = 1'b1;
        end
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(0, 99);
            idx  = BLOCK_W'($urandom);
            if (fill) begin
                if (pick < 95 || held_blocks.size() == 0) begin
                    op = OP_ALLOC;
                end else begin
                    op  = OP_FREE;
                    idx = BLOCK_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
                end
            end else if (pick < 45) begin
                op = OP_ALLOC;
            end else if (pick < 80 && held_blocks.size() != 0) begin
                op  = OP_FREE;
                idx = BLOCK_W'(held_blocks[$urandom_range(0, held_blocks.size() - 1)]);
            end else begin
                op = OP_W'($urandom_range(0, 3));
                if (op == OP_REFILL && $urandom_range(0, 7) != 0) begin
                    op = OP_NOP;
                end
                if ($urandom_range(0, 2) == 0) begin
                    // Just inside or just past the top of the active pool.
                    idx = BLOCK_W'(int'(pool_size) - 1 + $urandom_range(0, 1));
                end
            end
            send_request(op, idx, 1'b0, '0);
        end
    endtask

    // Result side: ready follows a pattern that is picked anew at random after each stretch,
    // from always ready to mostly stalled. Once per run, on request, ready is
    // held low for a long counted stretch.
    initial begin : ready_pattern
        int          stretch;
        ready_mode_t mode;
        m_ready = 1'b0;
        stretch = 0;
        mode    = READY_ALWAYS;
        forever begin
            @(negedge aclk);
            if (hold_request && !hold_done) begin
                m_ready = 1'b0;
                for (int held = 0; held < HOLD_CYCLES; held++) begin
                    @(negedge aclk);
                end
                hold_done = 1'b1;
            end
            if (stretch == 0) begin
                stretch = $urandom_range(20, 120);
                mode    = ready_mode_t'($urandom_range(0, 2));
            end
            stretch--;
            case (mode)
                READY_ALWAYS: m_ready = 1'b1;
                READY_HALF:   m_ready = ($urandom_range(0, 1) == 1);
                default:      m_ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Every accepted result beat is matched against the oldest owed result.
    always @(posedge aclk) begin : result_check
        alloc_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result beat: status %0d granted %0d used %0d failures %0d",
                         $time, m_status, m_granted_index, m_used_count, m_failure_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $display("%0t: status expected %0d, got %0d", $time, want.status, m_status);
                    error_count++;
                end
                if (m_granted_index !== want.granted) begin
                    $display("%0t: granted_index expected %0d, got %0d",
                             $time, want.granted, m_granted_index);
                    error_count++;
                end
                if (m_used_count !== want.used) begin
                    $display("%0t: used_count expected %0d, got %0d",
                             $time, want.used, m_used_count);
                    error_count++;
                end
                if (m_failure_count !== want.failures) begin
                    $display("%0t: failure_count expected %0d, got %0d",
                             $time, want.failures, m_failure_count);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a run that hangs ends here.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("fifo_free_list_block_allocator_core_tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        test_row_t row;

        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_operation   = OP_NOP;
        s_block_index = '0;
        burst_left    = 0;
        hold_request  = 1'b0;

        pool_cfg     = POOL_BLOCKS_RST;
        failed_total = '0;
        refill_pool_model();

        // Directed table. The pool comes out of reset with the whole depth.
        add_row(row_checked(OP_ALLOC, 10'd0, STAT_OK, 10'd0, 11'd1, 32'd0));
        add_row(row_checked(OP_FREE, 10'd0, STAT_OK, 10'd0, 11'd0, 32'd0));
        // A second free of the same block finds it not in use.
        add_row(row_checked(OP_FREE, 10'd0, STAT_NOT_USED, 10'd0, 11'd0, 32'd0));
        add_row(row_checked(OP_FREE, 10'd1023, STAT_NOT_USED, 10'd0, 11'd0, 32'd0));
        add_row(row_checked(OP_NOP, 10'd1023, STAT_OK, 10'd0, 11'd0, 32'd0));
        // Two-block pool: out-of-range frees, then run it dry.
        add_row(row_config(11'd2));
        add_row(row_checked(OP_REFILL, 10'd0, STAT_OK, 10'd0, 11'd0, 32'd0));
        add_row(row_checked(OP_FREE, 10'd2, STAT_RANGE, 10'd0, 11'd0, 32'd0));
        add_row(row_checked(OP_FREE, 10'd1023, STAT_RANGE, 10'd0, 11'd0, 32'd0));
        add_row(row_checked(OP_ALLOC, 10'd0, STAT_OK, 10'd0, 11'd1, 32'd0));
        add_row(row_checked(OP_ALLOC, 10'd0, STAT_OK, 10'd1, 11'd2, 32'd0));
        add_row(row_checked(OP_ALLOC, 10'd0, STAT_EXHAUSTED, 10'd0, 11'd2, 32'd1));
        add_row(row_checked(OP_ALLOC, 10'd0, STAT_EXHAUSTED, 10'd0, 11'd2, 32'd2));
        // A freed block goes to the tail of the ring and comes back out next.
        add_row(row_item(OP_FREE, 10'd1));
        add_row(row_item(OP_ALLOC, 10'd0));
        // A pool size of zero means the whole depth; the failure count survives.
        add_row(row_config(11'd0));
        add_row(row_checked(OP_REFILL, 10'd0, STAT_OK, 10'd0, 11'd0, 32'd2));
        add_row(row_checked(OP_ALLOC, 10'd1023, STAT_OK, 10'd0, 11'd1, 32'd2));
        // A size past the depth saturates, so the top index is in range.
        add_row(row_config(11'd2047));
        add_row(row_checked(OP_REFILL, 10'd0, STAT_OK, 10'd0, 11'd0, 32'd2));
        add_row(row_checked(OP_FREE, 10'd1023, STAT_NOT_USED, 10'd0, 11'd0, 32'd2));
        // A new size waits for the next pool reset.
        add_row(row_config(11'd1));
        add_row(row_item(OP_ALLOC, 10'd0));
        add_row(row_checked(OP_REFILL, 10'd0, STAT_OK, 10'd0, 11'd0, 32'd2));
        add_row(row_checked(OP_ALLOC, 10'd0, STAT_OK, 10'd0, 11'd1, 32'd2));
        add_row(row_checked(OP_ALLOC, 10'd0, STAT_EXHAUSTED, 10'd0, 11'd1, 32'd3));
        add_row(row_checked(OP_FREE, 10'd1, STAT_RANGE, 10'd0, 11'd1, 32'd3));
        add_row(row_checked(OP_FREE, 10'd0, STAT_OK, 10'd0, 11'd0, 32'd3));

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // The block runs its clearing pass now; the first beat simply waits for ready.
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.is_cfg) begin
                write_pool_blocks(row.cfg_value);
            end else begin
                send_request(row.op, row.idx, row.typed, row.result);
            end
        end

        // Random phases: pool size, pool reset or not, long hold-off, beats, fill mode.
        run_phase(11'd1024, 1'b1, 1'b0, 1200, 1'b1);
        run_phase(11'd7,    1'b1, 1'b1, 120,  1'b0);
        run_phase(11'd1,    1'b1, 1'b0, 60,   1'b0);
        // No pool reset: the zero size stays pending until the noise issues one.
        run_phase(11'd0,    1'b0, 1'b0, 40,   1'b0);
        run_phase(11'd2047, 1'b1, 1'b0, 60,   1'b0);
        run_phase(11'd13,   1'b1, 1'b0, 120,  1'b0);
        run_phase(11'd3,    1'b1, 1'b0, 50,   1'b0);

        drain_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0) begin
            $display("fifo_free_list_block_allocator_core_tb OK");
        end else begin
            $display("fifo_free_list_block_allocator_core_tb NOT OK");
        end
        $finish;
    end

endmodule
